>>> rtl/fwv_pkg.sv
// fwv_pkg: shared widths, fixed-point constants, pipeline latencies and types
// for the fractal worley voxel noise pipeline; no dependencies
`default_nettype none

package fwv_pkg;

    localparam int GRID_SIZE_DEF   = 128;
    localparam int MAX_OCTAVES_DEF = 4;

    localparam int VOX_W = 7;
    localparam int VOX_N = 1 << VOX_W;

    localparam int               OCT_W     = 3;
    localparam logic [OCT_W-1:0] OCT_RESET = 3'd4;

    // cell index reaches 2032 at the smallest grid, plus neighbour and hash offsets
    localparam int CELL_W = 11;
    localparam int NP_W   = 12;

    localparam int Q_W    = 24;
    localparam int Q_ONE  = 1 << Q_W;
    localparam int E_W    = Q_W + 2;
    localparam int D2_W   = 2 * E_W;
    localparam int DIST_W = E_W;
    localparam int SUM_W  = DIST_W + 1;

    localparam int OUT_W     = 17;
    localparam int OUT_SHIFT = 8;
    localparam int OUT_MAX   = (1 << OUT_W) - 1;

    localparam int DEC = 10000;

    // per-axis hash: r = (np * SCALE + OFFS) mod 1e4 with np = n + 1
    localparam int X_SCALE = 8975;
    localparam int X_OFFS  = 3998;
    localparam int Y_SCALE = 2973;
    localparam int Y_OFFS  = 8898;
    localparam int Z_SCALE = 1871;
    localparam int Z_OFFS  = 7104;

    localparam int CELL_OFF_X = 37;
    localparam int CELL_OFF_Y = 74;

    // reciprocals for exact floor division by constants
    localparam longint RCP_1E4_26 = 64'd109951163;
    localparam int     SH_1E4_26  = 40;
    localparam longint RCP_1E4_25 = 64'd54975582;
    localparam int     SH_1E4_25  = 39;
    localparam longint RCP_625_23 = 64'd13743896;
    localparam int     SH_625_23  = 33;

    localparam int     FRAC_Q24_INT  = 1677;
    localparam int     FRAC_Q24_REM  = 451;
    localparam longint MIX_SCALE     = 64'd12345678;
    localparam int     MIX_INT       = 1234;
    localparam int     MIX_REM       = 5678;
    localparam int     FRAC_019      = 3187671;

    localparam int LAT_FRAC  = 6;
    localparam int LAT_MIX   = 7;
    localparam int LAT_DIST  = 3;
    localparam int LAT_MIN   = 3;
    localparam int LAT_SQRT  = DIST_W;
    localparam int LAT_OCT   = 1 + LAT_FRAC + LAT_MIX + LAT_DIST + LAT_MIN + LAT_SQRT;
    localparam int LAT_TOTAL = 1 + LAT_OCT + 2;

    typedef logic [Q_W-1:0]    t_q24;
    typedef logic [D2_W-1:0]   t_d2;
    typedef logic [DIST_W-1:0] t_dist;

    function automatic t_d2 min3(t_d2 a, t_d2 b, t_d2 c);
        t_d2 m;
        m = (b < a) ? b : a;
        return (c < m) ? c : m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fwv_frac.sv
// fwv_frac: six-stage pipeline turning one integer cell coordinate into its
// q0.24 hash fraction; depends on fwv_pkg
`default_nettype none

module fwv_frac #(
    parameter int SCALE = fwv_pkg::X_SCALE,
    parameter int OFFS  = fwv_pkg::X_OFFS
) (
    input  wire logic                     i_clk,
    input  wire logic [fwv_pkg::NP_W-1:0] i_np,
    output fwv_pkg::t_q24                 o_frac
);

    localparam int T_W = 26;

    logic [T_W-1:0]        n_t;
    logic [T_W+27-1:0]     n_qp;
    logic [46:0]           n_zp;
    logic [T_W-1:0]        r_t;
    logic [T_W-1:0]        r_t2;
    logic [11:0]           r_q;
    logic [13:0]           r_r;
    logic [22:0]           r_y;
    logic [23:0]           r_r1677;
    logic [23:0]           r_r1677_d;
    logic [12:0]           r_z;
    fwv_pkg::t_q24         r_h;

    assign n_t  = T_W'(T_W'(i_np) * T_W'(SCALE) + T_W'(OFFS));
    assign n_qp = (T_W + 27)'(r_t) * (T_W + 27)'(fwv_pkg::RCP_1E4_26);
    assign n_zp = 47'(r_y) * 47'(fwv_pkg::RCP_625_23);

    always_ff @(posedge i_clk) begin
        r_t       <= n_t;
        r_t2      <= r_t;
        r_q       <= n_qp[fwv_pkg::SH_1E4_26 +: 12];
        r_r       <= 14'(r_t2 - T_W'(r_q) * T_W'(fwv_pkg::DEC));
        r_y       <= 23'(23'(r_r) * 23'(fwv_pkg::FRAC_Q24_REM));
        r_r1677   <= 24'(24'(r_r) * 24'(fwv_pkg::FRAC_Q24_INT));
        r_z       <= n_zp[fwv_pkg::SH_625_23 +: 13];
        r_r1677_d <= r_r1677;
        r_h       <= r_r1677_d + 24'(r_z);
    end

    assign o_frac = r_h;

endmodule

`default_nettype wire

>>> rtl/fwv_mix.sv
// fwv_mix: seven-stage pipeline mixing three axis fractions into one cell
// hash; depends on fwv_pkg
`default_nettype none

module fwv_mix (
    input  wire logic          i_clk,
    input  wire fwv_pkg::t_q24 i_hx,
    input  wire fwv_pkg::t_q24 i_hy,
    input  wire fwv_pkg::t_q24 i_hz,
    output fwv_pkg::t_q24      o_hash
);

    logic [47:0]   r_pxy, r_pyz, r_pxz;
    logic [48:0]   n_s;
    logic [49:0]   n_p;
    logic [24:0]   r_s, r_s_d;
    logic [25:0]   r_p, r_p2, r_p3, r_p4, r_p5;
    logic [50:0]   n_sap;
    logic [11:0]   r_sa, r_sa2;
    logic [13:0]   r_sb;
    logic [25:0]   r_x;
    logic [23:0]   r_sb1234, r_sb1234_d;
    logic [35:0]   n_sa12;
    logic [23:0]   r_sa12, r_sa12_d;
    logic [52:0]   n_qxp;
    logic [12:0]   r_qx;
    logic [26:0]   n_hash;
    fwv_pkg::t_q24 r_hash;

    assign n_s    = 49'(r_pxz) + 49'(r_pyz);
    assign n_p    = 50'(r_pxy) + 50'(r_pyz) + 50'(r_pxz);
    assign n_sap  = 51'(r_s) * 51'(fwv_pkg::RCP_1E4_25);
    assign n_sa12 = 36'(r_sa2) * 36'(fwv_pkg::MIX_SCALE);
    assign n_qxp  = 53'(r_x) * 53'(fwv_pkg::RCP_1E4_26);
    assign n_hash = 27'(r_sa12_d) + 27'(r_sb1234_d) + 27'(r_qx) + 27'(r_p5)
                  + 27'(fwv_pkg::FRAC_019);

    always_ff @(posedge i_clk) begin
        // products of the axis fractions; the xz and yz products are shared between both sums
        r_pxy      <= 48'(i_hx) * 48'(i_hy);
        r_pyz      <= 48'(i_hy) * 48'(i_hz);
        r_pxz      <= 48'(i_hx) * 48'(i_hz);
        r_s        <= n_s[48:24];
        r_p        <= n_p[49:24];
        // s = sa * 1e4 + sb
        r_sa       <= n_sap[fwv_pkg::SH_1E4_25 +: 12];
        r_s_d      <= r_s;
        r_p2       <= r_p;
        r_sb       <= 14'(r_s_d - 25'(r_sa) * 25'(fwv_pkg::DEC));
        r_sa2      <= r_sa;
        r_p3       <= r_p2;
        r_x        <= 26'(26'(r_sb) * 26'(fwv_pkg::MIX_REM));
        r_sb1234   <= 24'(24'(r_sb) * 24'(fwv_pkg::MIX_INT));
        r_sa12     <= n_sa12[23:0];
        r_p4       <= r_p3;
        r_qx       <= n_qxp[fwv_pkg::SH_1E4_26 +: 13];
        r_sb1234_d <= r_sb1234;
        r_sa12_d   <= r_sa12;
        r_p5       <= r_p4;
        r_hash     <= n_hash[23:0];
    end

    assign o_hash = r_hash;

endmodule

`default_nettype wire

>>> rtl/fwv_isqrt.sv
// fwv_isqrt: floor square root of the squared distance, one result bit per
// pipeline stage; depends on fwv_pkg
`default_nettype none

module fwv_isqrt (
    input  wire logic         i_clk,
    input  wire fwv_pkg::t_d2 i_val,
    output fwv_pkg::t_dist    o_root
);

    localparam int STEPS = fwv_pkg::DIST_W;

    fwv_pkg::t_d2 r_v   [STEPS-1];
    fwv_pkg::t_d2 r_res [STEPS];

    for (genvar gs = 0; gs < STEPS; gs++) begin : g_step
        localparam fwv_pkg::t_d2 BIT = fwv_pkg::t_d2'(1) << (2 * (STEPS - 1 - gs));
        fwv_pkg::t_d2 n_vin;
        fwv_pkg::t_d2 n_rin;
        fwv_pkg::t_d2 n_try;
        logic         n_ge;

        if (gs == 0) begin : g_first
            assign n_vin = i_val;
            assign n_rin = '0;
        end else begin : g_next
            assign n_vin = r_v[gs-1];
            assign n_rin = r_res[gs-1];
        end

        assign n_try = n_rin + BIT;
        assign n_ge  = (n_vin >= n_try);

        always_ff @(posedge i_clk) begin
            r_res[gs] <= n_ge ? (n_rin >> 1) + BIT : n_rin >> 1;
        end

        if (gs < STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_v[gs] <= n_ge ? n_vin - n_try : n_vin;
            end
        end
    end

    assign o_root = r_res[STEPS-1][STEPS-1:0];

endmodule

`default_nettype wire

>>> rtl/fwv_octave.sv
// fwv_octave: one noise octave, from voxel index to nearest feature distance
// over the 27 neighbouring cells; depends on fwv_pkg, fwv_frac, fwv_mix, fwv_isqrt
`default_nettype none

module fwv_octave #(
    parameter int GRID_SIZE = fwv_pkg::GRID_SIZE_DEF,
    parameter int OCT       = 0
) (
    input  wire logic                      i_clk,
    input  wire logic [fwv_pkg::VOX_W-1:0] i_vox_x,
    input  wire logic [fwv_pkg::VOX_W-1:0] i_vox_y,
    input  wire logic [fwv_pkg::VOX_W-1:0] i_vox_z,
    output fwv_pkg::t_dist                 o_dist
);

    localparam int NXY   = 6;
    localparam int NZ    = 3;
    localparam int NCELL = 27;
    localparam int FDLY  = fwv_pkg::LAT_FRAC + fwv_pkg::LAT_MIX + 1;
    localparam int E_W   = fwv_pkg::E_W;

    logic [fwv_pkg::CELL_W-1:0] w_cell_tab [fwv_pkg::VOX_N];
    fwv_pkg::t_q24              w_frac_tab [fwv_pkg::VOX_N];

    // domain coordinate index * 4 * 2^k / grid, split into cell and fraction
    for (genvar gv = 0; gv < fwv_pkg::VOX_N; gv++) begin : g_tab
        localparam longint NUM = longint'(gv) * 4 * (longint'(1) << OCT);
        assign w_cell_tab[gv] = fwv_pkg::CELL_W'(NUM / GRID_SIZE);
        assign w_frac_tab[gv] = fwv_pkg::Q_W'(((NUM % GRID_SIZE) << fwv_pkg::Q_W) / GRID_SIZE);
    end

    logic [fwv_pkg::CELL_W-1:0] r_cx, r_cy, r_cz;
    fwv_pkg::t_q24              r_fx [FDLY];
    fwv_pkg::t_q24              r_fy [FDLY];
    fwv_pkg::t_q24              r_fz [FDLY];

    always_ff @(posedge i_clk) begin
        r_cx    <= w_cell_tab[i_vox_x];
        r_cy    <= w_cell_tab[i_vox_y];
        r_cz    <= w_cell_tab[i_vox_z];
        r_fx[0] <= w_frac_tab[i_vox_x];
        r_fy[0] <= w_frac_tab[i_vox_y];
        r_fz[0] <= w_frac_tab[i_vox_z];
        for (int i = 1; i < FDLY; i++) begin
            r_fx[i] <= r_fx[i-1];
            r_fy[i] <= r_fy[i-1];
            r_fz[i] <= r_fz[i-1];
        end
    end

    fwv_pkg::t_q24 w_hx [NXY];
    fwv_pkg::t_q24 w_hy [NXY];
    fwv_pkg::t_q24 w_hz [NZ];

    // axis fractions for cell-1..cell+1 and the offset copies used by the hash
    for (genvar gj = 0; gj < NXY; gj++) begin : g_fxy
        localparam int XO = (gj < 3) ? gj : gj - 3 + fwv_pkg::CELL_OFF_X;
        localparam int YO = (gj < 3) ? gj : gj - 3 + fwv_pkg::CELL_OFF_Y;

        fwv_frac #(.SCALE(fwv_pkg::X_SCALE), .OFFS(fwv_pkg::X_OFFS)) u_fx (
            .i_clk  (i_clk),
            .i_np   (fwv_pkg::NP_W'(r_cx) + fwv_pkg::NP_W'(XO)),
            .o_frac (w_hx[gj])
        );

        fwv_frac #(.SCALE(fwv_pkg::Y_SCALE), .OFFS(fwv_pkg::Y_OFFS)) u_fy (
            .i_clk  (i_clk),
            .i_np   (fwv_pkg::NP_W'(r_cy) + fwv_pkg::NP_W'(YO)),
            .o_frac (w_hy[gj])
        );
    end

    for (genvar gj = 0; gj < NZ; gj++) begin : g_fz
        fwv_frac #(.SCALE(fwv_pkg::Z_SCALE), .OFFS(fwv_pkg::Z_OFFS)) u_fz (
            .i_clk  (i_clk),
            .i_np   (fwv_pkg::NP_W'(r_cz) + fwv_pkg::NP_W'(gj)),
            .o_frac (w_hz[gj])
        );
    end

    fwv_pkg::t_d2 r_d2 [NCELL];

    for (genvar gc = 0; gc < NCELL; gc++) begin : g_cell
        localparam int DX = gc / 9;
        localparam int DY = (gc / 3) % 3;
        localparam int DZ = gc % 3;
        localparam logic signed [E_W-1:0] OX = E_W'((DX - 1) * fwv_pkg::Q_ONE);
        localparam logic signed [E_W-1:0] OY = E_W'((DY - 1) * fwv_pkg::Q_ONE);
        localparam logic signed [E_W-1:0] OZ = E_W'((DZ - 1) * fwv_pkg::Q_ONE);

        fwv_pkg::t_q24           w_px, w_py, w_pz;
        logic signed [E_W-1:0]   r_ex, r_ey, r_ez;
        logic signed [2*E_W-1:0] n_sqx, n_sqy, n_sqz;
        fwv_pkg::t_d2            r_sqx, r_sqy, r_sqz;

        fwv_mix u_mx (
            .i_clk (i_clk), .i_hx(w_hx[DX]), .i_hy(w_hy[DY]), .i_hz(w_hz[DZ]),
            .o_hash(w_px)
        );
        fwv_mix u_my (
            .i_clk (i_clk), .i_hx(w_hx[DX+3]), .i_hy(w_hy[DY]), .i_hz(w_hz[DZ]),
            .o_hash(w_py)
        );
        fwv_mix u_mz (
            .i_clk (i_clk), .i_hx(w_hx[DX]), .i_hy(w_hy[DY+3]), .i_hz(w_hz[DZ]),
            .o_hash(w_pz)
        );

        assign n_sqx = r_ex * r_ex;
        assign n_sqy = r_ey * r_ey;
        assign n_sqz = r_ez * r_ez;

        always_ff @(posedge i_clk) begin
            r_ex     <= $signed({2'b00, w_px}) - $signed({2'b00, r_fx[FDLY-1]}) + OX;
            r_ey     <= $signed({2'b00, w_py}) - $signed({2'b00, r_fy[FDLY-1]}) + OY;
            r_ez     <= $signed({2'b00, w_pz}) - $signed({2'b00, r_fz[FDLY-1]}) + OZ;
            r_sqx    <= fwv_pkg::t_d2'(n_sqx);
            r_sqy    <= fwv_pkg::t_d2'(n_sqy);
            r_sqz    <= fwv_pkg::t_d2'(n_sqz);
            r_d2[gc] <= r_sqx + r_sqy + r_sqz;
        end
    end

    // registered three-way minimum tree, 27 -> 9 -> 3 -> 1
    fwv_pkg::t_d2 r_m1 [9];
    fwv_pkg::t_d2 r_m2 [3];
    fwv_pkg::t_d2 r_m3;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            r_m1[i] <= fwv_pkg::min3(r_d2[3*i], r_d2[3*i+1], r_d2[3*i+2]);
        end
        for (int i = 0; i < 3; i++) begin
            r_m2[i] <= fwv_pkg::min3(r_m1[3*i], r_m1[3*i+1], r_m1[3*i+2]);
        end
        r_m3 <= fwv_pkg::min3(r_m2[0], r_m2[1], r_m2[2]);
    end

    fwv_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_val  (r_m3),
        .o_root (o_dist)
    );

endmodule

`default_nettype wire

>>> rtl/fbm_worley_noise_voxel.sv
// fractal worley noise for one voxel of a cubic grid, one octave pipeline each
// one request taken every clock
// latency is set by the hash pipelines and the one-bit-per-stage square root
// busy is never raised and o_done cannot be held off by the receiver
// synchronous reset clears the valid line and sets octave_count to 4
// depends on fwv_pkg and fwv_octave
`default_nettype none

module fbm_worley_noise_voxel #(
    parameter int GRID_SIZE   = fwv_pkg::GRID_SIZE_DEF,
    parameter int MAX_OCTAVES = fwv_pkg::MAX_OCTAVES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [fwv_pkg::VOX_W-1:0] i_voxel_x,
    input  wire logic [fwv_pkg::VOX_W-1:0] i_voxel_y,
    input  wire logic [fwv_pkg::VOX_W-1:0] i_voxel_z,
    input  wire logic                      i_cfg_we,
    input  wire logic [fwv_pkg::OCT_W-1:0] i_cfg_wdata,
    output logic                           o_done,
    output logic [fwv_pkg::OUT_W-1:0]      o_noise_value
);

    localparam int LAT   = fwv_pkg::LAT_TOTAL;
    localparam int OCT_W = fwv_pkg::OCT_W;
    localparam int SUM_W = fwv_pkg::SUM_W;
    localparam int SC_W  = SUM_W - fwv_pkg::OUT_SHIFT;

    logic [LAT-1:0]            r_vld;
    logic [OCT_W-1:0]          r_oct_cnt;
    logic [fwv_pkg::VOX_W-1:0] r_vx, r_vy, r_vz;
    logic [OCT_W-1:0]          n_oct_eff;
    logic [SUM_W-1:0]          n_sum;
    logic [SUM_W-1:0]          r_sum;
    logic [SC_W-1:0]           n_scaled;
    logic [fwv_pkg::OUT_W-1:0] r_noise;
    fwv_pkg::t_dist            w_dist [MAX_OCTAVES];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_oct_cnt <= fwv_pkg::OCT_RESET;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
            if (i_cfg_we) begin
                r_oct_cnt <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_vx <= i_voxel_x;
            r_vy <= i_voxel_y;
            r_vz <= i_voxel_z;
        end
    end

    for (genvar gk = 0; gk < MAX_OCTAVES; gk++) begin : g_oct
        fwv_octave #(.GRID_SIZE(GRID_SIZE), .OCT(gk)) u_oct (
            .i_clk   (i_clk),
            .i_vox_x (r_vx),
            .i_vox_y (r_vy),
            .i_vox_z (r_vz),
            .o_dist  (w_dist[gk])
        );
    end

    assign n_oct_eff = (r_oct_cnt > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : r_oct_cnt;

    // octave k contributes distance / 2^(k+1)
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < MAX_OCTAVES; k++) begin
            if (OCT_W'(k) < n_oct_eff) begin
                n_sum = n_sum + SUM_W'(w_dist[k] >> (k + 1));
            end
        end
    end

    assign n_scaled = r_sum[SUM_W-1:fwv_pkg::OUT_SHIFT];

    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_noise <= (n_scaled > SC_W'(fwv_pkg::OUT_MAX)) ? fwv_pkg::OUT_W'(fwv_pkg::OUT_MAX)
                                                        : fwv_pkg::OUT_W'(n_scaled);
    end

    assign o_done        = r_vld[LAT-1];
    assign o_noise_value = r_noise;

endmodule

`default_nettype wire

>>> rtl/fwv_chk.sv
// fwv_chk: port-level checks of request and result timing, busy and known results,
// bound to the top level; depends on fwv_pkg and fbm_worley_noise_voxel
`default_nettype none

module fwv_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      o_done,
    input wire logic [fwv_pkg::OUT_W-1:0] o_noise_value
);

    // every request yields exactly one result after the fixed latency
    a_req_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(fwv_pkg::LAT_TOTAL) o_done)
        else $error("request without result at fixed latency");

    a_done_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, fwv_pkg::LAT_TOTAL))
        else $error("result without matching request");

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised by a fully pipelined block");

    a_val_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_noise_value))
        else $error("result value unknown");

endmodule

bind fbm_worley_noise_voxel fwv_chk u_fwv_chk (.*);

`default_nettype wire
